[hw/rtl/text_console_char_writer_unit_assert.svh]
// Assertion macros used by the console writer datapath.
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("console writer check failed");
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("console writer check failed");
`else
`define TCW_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/tcw_pkg.sv]
// Shared types, constants and control word layout of the console writer.
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_LAST  = (ROWS - 1) * COLUMNS - 1;
  localparam int CELL_LAST  = CELL_COUNT - 1;

  localparam int PC_W = 5;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_location;
    logic [7:0]  cell_char;
    logic [3:0]  cell_fg;
    logic [3:0]  cell_bg;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_PUT,
    OP_PTR_ZERO,
    OP_HOME,
    OP_COPY,
    OP_COPY_DRAIN,
    OP_BLANK,
    OP_ROW_LAST,
    OP_READ,
    OP_FINISH
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_KIND_CLEAR,
    C_KIND_READ,
    C_KIND_NOT_PUT,
    C_NO_SCROLL,
    C_COPY_MORE,
    C_CELL_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic            take;
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic kind_clear;
    logic kind_read;
    logic kind_not_put;
    logic no_scroll;
    logic copy_more;
    logic cell_more;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

[hw/rtl/text_console_char_writer_unit.sv]
// Top level of the text console character writer.
`default_nettype none
// A text console of 80 by 25 cells, 16 bits each (character, foreground,
// background), with a cursor. Each input word is a put-character, a
// clear-screen or a read-cell request, or an unused kind that changes
// nothing, and yields one result word carrying the cursor and its linear
// location. A microcoded step counter drives a single-port-write cell
// store; a scroll runs 1920 copy steps through the pipelined store read, a
// drain step and 80 blanking steps, and a clear screen blanks one cell a
// cycle. After reset a clearing pass blanks the store before the first
// input word is accepted; configuration writes are taken throughout. A
// finished result waits in the output register and only holds the block
// back once the next result is ready.
module text_console_char_writer_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tcw_pkg::out_word_t out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [3:0]    cfg_wdata
);
  import tcw_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  assign in_stall = !ctl.take;

  tcw_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl)
  );

  tcw_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
`default_nettype wire

[hw/rtl/tcw_sequencer.sv]
// Microcode store, step counter and jump logic of the console writer.
`default_nettype none
module tcw_sequencer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  tcw_pkg::stat_t    stat,
  output tcw_pkg::ctl_t     ctl
);
  import tcw_pkg::*;

  localparam logic [PC_W-1:0] ST_BOOT      = 5'd0;
  localparam logic [PC_W-1:0] ST_BOOT_FILL = 5'd1;
  localparam logic [PC_W-1:0] ST_IDLE      = 5'd2;
  localparam logic [PC_W-1:0] ST_TEST_CLR  = 5'd3;
  localparam logic [PC_W-1:0] ST_TEST_RD   = 5'd4;
  localparam logic [PC_W-1:0] ST_TEST_PUT  = 5'd5;
  localparam logic [PC_W-1:0] ST_PUT       = 5'd6;
  localparam logic [PC_W-1:0] ST_SCR_INIT  = 5'd7;
  localparam logic [PC_W-1:0] ST_SCR_COPY  = 5'd8;
  localparam logic [PC_W-1:0] ST_SCR_DRAIN = 5'd9;
  localparam logic [PC_W-1:0] ST_SCR_BLANK = 5'd10;
  localparam logic [PC_W-1:0] ST_SCR_ROW   = 5'd11;
  localparam logic [PC_W-1:0] ST_CLR_HOME  = 5'd12;
  localparam logic [PC_W-1:0] ST_CLR_FILL  = 5'd13;
  localparam logic [PC_W-1:0] ST_CLR_DONE  = 5'd14;
  localparam logic [PC_W-1:0] ST_READ      = 5'd15;
  localparam logic [PC_W-1:0] ST_FINISH    = 5'd16;
  localparam logic [PC_W-1:0] ST_RETURN    = 5'd17;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{take: 1'b0, op: OP_NONE, cond: C_NEVER, target: ST_IDLE};
    case (pc)
      ST_BOOT:      w.op = OP_PTR_ZERO;
      ST_BOOT_FILL: w = '{take: 1'b0, op: OP_BLANK, cond: C_CELL_MORE, target: ST_BOOT_FILL};
      ST_IDLE:      w = '{take: 1'b1, op: OP_LATCH, cond: C_NO_ACCEPT, target: ST_IDLE};
      ST_TEST_CLR:  w = '{take: 1'b0, op: OP_NONE, cond: C_KIND_CLEAR, target: ST_CLR_HOME};
      ST_TEST_RD:   w = '{take: 1'b0, op: OP_NONE, cond: C_KIND_READ, target: ST_READ};
      ST_TEST_PUT:  w = '{take: 1'b0, op: OP_NONE, cond: C_KIND_NOT_PUT, target: ST_FINISH};
      ST_PUT:       w.op = OP_PUT;
      ST_SCR_INIT:  w = '{take: 1'b0, op: OP_PTR_ZERO, cond: C_NO_SCROLL, target: ST_FINISH};
      ST_SCR_COPY:  w = '{take: 1'b0, op: OP_COPY, cond: C_COPY_MORE, target: ST_SCR_COPY};
      ST_SCR_DRAIN: w.op = OP_COPY_DRAIN;
      ST_SCR_BLANK: w = '{take: 1'b0, op: OP_BLANK, cond: C_CELL_MORE, target: ST_SCR_BLANK};
      ST_SCR_ROW:   w = '{take: 1'b0, op: OP_ROW_LAST, cond: C_ALWAYS, target: ST_FINISH};
      ST_CLR_HOME:  w.op = OP_HOME;
      ST_CLR_FILL:  w = '{take: 1'b0, op: OP_BLANK, cond: C_CELL_MORE, target: ST_CLR_FILL};
      ST_CLR_DONE:  w = '{take: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: ST_FINISH};
      ST_READ:      w.op = OP_READ;
      ST_FINISH:    w = '{take: 1'b0, op: OP_FINISH, cond: C_OUT_BUSY, target: ST_FINISH};
      ST_RETURN:    w = '{take: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: ST_IDLE};
      default:      w = '{take: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: ST_IDLE};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            jump;

  assign ctl = ucode(pc_r);

  always_comb begin
    case (ctl.cond)
      C_NEVER:        jump = 1'b0;
      C_ALWAYS:       jump = 1'b1;
      C_NO_ACCEPT:    jump = !in_valid;
      C_KIND_CLEAR:   jump = stat.kind_clear;
      C_KIND_READ:    jump = stat.kind_read;
      C_KIND_NOT_PUT: jump = stat.kind_not_put;
      C_NO_SCROLL:    jump = stat.no_scroll;
      C_COPY_MORE:    jump = stat.copy_more;
      C_CELL_MORE:    jump = stat.cell_more;
      C_OUT_BUSY:     jump = stat.out_busy;
      default:        jump = 1'b0;
    endcase
    pc_nxt = jump ? ctl.target : pc_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_BOOT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tcw_datapath.sv]
// Cursor, cell store, copy pointer and result register of the console writer.
`default_nettype none
`include "text_console_char_writer_unit_assert.svh"
module tcw_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  tcw_pkg::ctl_t      ctl,
  output tcw_pkg::stat_t     stat,
  input  wire logic          in_valid,
  input  tcw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tcw_pkg::out_word_t out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [3:0]    cfg_wdata
);
  import tcw_pkg::*;

  logic [15:0] mem [CELL_COUNT];

  logic [3:0]  fg_r, bg_r;
  in_word_t    item_r;
  logic [6:0]  col_r, col_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [10:0] ptr_r, wptr_r;
  logic        pend_r;
  logic [15:0] rdata_r;
  logic        out_valid_r;
  out_word_t   out_r;

  logic        wr_en, rd_en;
  logic [10:0] wr_addr, rd_addr, cur_addr;
  logic [15:0] wr_data;
  logic [6:0]  put_col;
  logic [4:0]  put_row;
  logic        printable, fin_load, read_hit;
  out_word_t   result;

  assign cur_addr  = 11'(row_r) * 11'(COLUMNS) + 11'(col_r);
  assign printable = !item_r.char_code[7] && (item_r.char_code[6:5] != 2'd0);
  assign fin_load  = (ctl.op == OP_FINISH) && !(out_valid_r && out_stall);
  assign read_hit  = (item_r.kind == KIND_READ) && (item_r.cell_index < 11'(CELL_COUNT));

  assign stat.kind_clear   = item_r.kind == KIND_CLEAR;
  assign stat.kind_read    = item_r.kind == KIND_READ;
  assign stat.kind_not_put = item_r.kind != KIND_PUT;
  assign stat.no_scroll    = row_r < 5'(ROWS);
  assign stat.copy_more    = ptr_r != 11'(COPY_LAST);
  assign stat.cell_more    = ptr_r != 11'(CELL_LAST);
  assign stat.out_busy     = out_valid_r && out_stall;

  always_comb begin
    put_col = col_r;
    put_row = row_r;
    case (item_r.char_code)
      CHAR_BS:  put_col = (col_r != 7'd0) ? col_r - 7'd1 : col_r;
      CHAR_TAB: put_col = col_r - (col_r % 7'(TAB_STOP)) + 7'(TAB_STOP);
      CHAR_CR:  put_col = 7'd0;
      CHAR_LF: begin
        put_col = 7'd0;
        put_row = row_r + 5'd1;
      end
      default: begin
        if (printable) begin
          put_col = col_r + 7'd1;
        end
      end
    endcase
    if (put_col >= 7'(COLUMNS)) begin
      put_col = 7'd0;
      put_row = put_row + 5'd1;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = BLANK_CELL;
    rd_en   = 1'b0;
    rd_addr = ptr_r + 11'(COLUMNS);
    case (ctl.op)
      OP_PUT: begin
        col_nxt = put_col;
        row_nxt = put_row;
        wr_en   = printable;
        wr_addr = cur_addr;
        wr_data = {bg_r, fg_r, item_r.char_code};
      end
      OP_HOME: begin
        col_nxt = 7'd0;
        row_nxt = 5'd0;
      end
      OP_COPY: begin
        rd_en   = 1'b1;
        wr_en   = pend_r;
        wr_addr = wptr_r;
        wr_data = rdata_r;
      end
      OP_COPY_DRAIN: begin
        wr_en   = 1'b1;
        wr_addr = wptr_r;
        wr_data = rdata_r;
      end
      OP_BLANK:    wr_en = 1'b1;
      OP_ROW_LAST: row_nxt = 5'(ROWS - 1);
      OP_READ: begin
        rd_en   = 1'b1;
        rd_addr = item_r.cell_index;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.cursor_column   = col_r;
    result.cursor_row      = row_r;
    result.cursor_location = cur_addr;
    result.cell_char       = read_hit ? rdata_r[7:0] : 8'd0;
    result.cell_fg         = read_hit ? rdata_r[11:8] : 4'd0;
    result.cell_bg         = read_hit ? rdata_r[15:12] : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r        <= 4'd15;
      bg_r        <= 4'd0;
      col_r       <= 7'd0;
      row_r       <= 5'd0;
      ptr_r       <= 11'd0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_FG) begin
        fg_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_BG) begin
        bg_r <= cfg_wdata;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      case (ctl.op)
        OP_PTR_ZERO, OP_HOME: begin
          ptr_r  <= 11'd0;
          pend_r <= 1'b0;
        end
        OP_COPY: begin
          ptr_r  <= ptr_r + 11'd1;
          pend_r <= 1'b1;
        end
        OP_COPY_DRAIN: pend_r <= 1'b0;
        OP_BLANK:      ptr_r  <= ptr_r + 11'd1;
        default: ;
      endcase
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_COPY) begin
      wptr_r <= ptr_r;
    end
    if (ctl.op == OP_LATCH && in_valid) begin
      item_r <= in_data;
    end
    if (fin_load) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TCW_ASSERT_SAME(a_idle_row, clk, rst_n, ctl.take, row_r < 5'(ROWS))
  `TCW_ASSERT_SAME(a_col_range, clk, rst_n, 1'b1, col_r < 7'(COLUMNS))
  `TCW_ASSERT_SAME(a_wr_range, clk, rst_n, wr_en, wr_addr < 11'(CELL_COUNT))
  `TCW_ASSERT_NEXT(a_out_load, clk, rst_n, fin_load, out_valid_r)
  `TCW_ASSERT_SAME(a_copy_order, clk, rst_n, wr_en && ctl.op == OP_COPY, wptr_r < rd_addr)

endmodule
`default_nettype wire

[bench/text_console_char_writer_unit_tb.sv]
// Self-checking bench for the text console character writer: directed table, then random words.
`timescale 1ns / 1ps

module text_console_char_writer_unit_tb;
  import tcw_pkg::*;

  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam logic [7:0] PRINT_FIRST = 8'h20;
  localparam logic [7:0] PRINT_LAST  = 8'h7F;
  localparam int INDEX_MAX     = 2047;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_WORDS   = 54;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 2100;
  localparam int STALL_LIMIT   = 20000;
  localparam int REPORT_LIMIT  = 10;

  localparam out_word_t HOME_EMPTY = '0;
  localparam out_word_t HOME_BLANK = '{cursor_column: 7'd0, cursor_row: 5'd0,
                                       cursor_location: 11'd0,
                                       cell_char: BLANK_CELL[7:0],
                                       cell_fg: BLANK_CELL[11:8],
                                       cell_bg: BLANK_CELL[15:12]};

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [10:0] index;
    int          reps;
    bit          typed;
    out_word_t   want;
  } script_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_index = REG_FG;
  logic [3:0] cfg_wdata = 4'd0;

  logic [15:0] screen_mem [CELL_COUNT];
  int          cur_col;
  int          cur_row;
  logic [3:0]  fg_reg = 4'd15;
  logic [3:0]  bg_reg = 4'd0;

  out_word_t   cursor_reports [$];
  script_row_t directed_rows [DIRECTED_ROWS];

  int  fault_count     = 0;
  int  reports_checked = 0;
  int  words_sent      = 0;
  int  read_count      = 0;
  int  scroll_count    = 0;
  int  clear_count     = 0;
  int  colour_settings = 0;
  int  idle_cycles     = 0;
  int  out_hold        = 0;
  bit  in_calm         = 1'b0;
  bit  out_calm        = 1'b0;

  text_console_char_writer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_mem[i] = BLANK_CELL;
  endfunction

  function automatic out_word_t apply_console_word(in_word_t w);
    out_word_t   r;
    logic [15:0] cell_word;
    cell_word = '0;
    case (w.kind)
      KIND_PUT: begin
        case (w.char_code)
          CHAR_BS: if (cur_col > 0) cur_col--;
          CHAR_TAB: cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
          CHAR_CR: cur_col = 0;
          CHAR_LF: begin
            cur_col = 0;
            cur_row++;
          end
          default: begin
            if (w.char_code >= PRINT_FIRST && w.char_code <= PRINT_LAST) begin
              screen_mem[cur_row * COLUMNS + cur_col] = {bg_reg, fg_reg, w.char_code};
              cur_col++;
            end
          end
        endcase
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i <= COPY_LAST; i++) screen_mem[i] = screen_mem[i + COLUMNS];
          for (int i = COPY_LAST + 1; i <= CELL_LAST; i++) screen_mem[i] = BLANK_CELL;
          cur_row = ROWS - 1;
          scroll_count++;
        end
      end
      KIND_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
      KIND_READ: begin
        if (w.cell_index < CELL_COUNT) cell_word = screen_mem[w.cell_index];
        read_count++;
      end
      default: ;
    endcase
    r.cursor_column   = 7'(cur_col);
    r.cursor_row      = 5'(cur_row);
    r.cursor_location = 11'(cur_row * COLUMNS + cur_col);
    r.cell_char       = cell_word[7:0];
    r.cell_fg         = cell_word[11:8];
    r.cell_bg         = cell_word[15:12];
    return r;
  endfunction

  function automatic in_word_t random_console_word();
    in_word_t w;
    int       pick;
    int       loc;
    w.kind       = KIND_PUT;
    w.char_code  = 8'($urandom_range(PRINT_FIRST, PRINT_LAST));
    w.cell_index = 11'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w.char_code = CHAR_LF;
    end else if (pick < 12) begin
      w.char_code = CHAR_CR;
    end else if (pick < 16) begin
      w.char_code = CHAR_BS;
    end else if (pick < 22) begin
      w.char_code = CHAR_TAB;
    end else if (pick < 27) begin
      w.char_code = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hFF))
                                         : 8'($urandom_range(0, PRINT_FIRST - 1));
    end else if (pick < 40) begin
      w.kind      = KIND_READ;
      w.char_code = 8'($urandom);
      loc = cur_row * COLUMNS + cur_col - int'($urandom_range(1, 12));
      case ($urandom_range(0, 9))
        0:             w.cell_index = 11'($urandom_range(CELL_COUNT, INDEX_MAX));
        1, 2, 3, 4:    w.cell_index = 11'((loc < 0) ? 0 : loc);
        default:       w.cell_index = 11'($urandom_range(0, CELL_LAST));
      endcase
    end else if (pick < 42) begin
      w.kind      = KIND_CLEAR;
      w.char_code = 8'($urandom);
    end else if (pick < 44) begin
      w.kind      = KIND_SPARE;
      w.char_code = 8'($urandom);
    end
    return w;
  endfunction

  task automatic set_colours(input logic [3:0] fg, input logic [3:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FG;
    cfg_wdata <= fg;
    @(posedge clk);
    cfg_index <= REG_BG;
    cfg_wdata <= bg;
    @(posedge clk);
    cfg_we <= 1'b0;
    fg_reg = fg;
    bg_reg = bg;
    colour_settings++;
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int        gap;
    out_word_t model_out;
    if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    model_out = apply_console_word(w);
    cursor_reports.push_back(typed ? want : model_out);
    words_sent++;
  endtask

  task automatic note_fault(input string what, input out_word_t want, input out_word_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("%s: want col %0d row %0d loc %0d char %02h fg %0d bg %0d",
               what, want.cursor_column, want.cursor_row, want.cursor_location,
               want.cell_char, want.cell_fg, want.cell_bg);
      $display("  got col %0d row %0d loc %0d char %02h fg %0d bg %0d",
               got.cursor_column, got.cursor_row, got.cursor_location,
               got.cell_char, got.cell_fg, got.cell_bg);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cursor_reports.size() == 0) begin
          note_fault("unrequested result word", HOME_EMPTY, out_data);
        end else begin
          want = cursor_reports.pop_front();
          if (out_data.cursor_column !== want.cursor_column ||
              out_data.cursor_row !== want.cursor_row ||
              out_data.cursor_location !== want.cursor_location ||
              out_data.cell_char !== want.cell_char ||
              out_data.cell_fg !== want.cell_fg ||
              out_data.cell_bg !== want.cell_bg)
            note_fault("result word mismatch", want, out_data);
        end
        reports_checked++;
        if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
        out_hold = out_calm ? 0 : $urandom_range(0, 3);
      end else if (out_valid && out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles with no word moving.", STALL_LIMIT);
      $display("text_console_char_writer_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_word_t w;
    int       p;
    int       k;
    int       n;
    directed_rows[0]  = '{KIND_READ,  8'h00,    11'd0,    1,  1'b1, HOME_BLANK};
    directed_rows[1]  = '{KIND_READ,  8'h00,    11'd1999, 1,  1'b1, HOME_BLANK};
    directed_rows[2]  = '{KIND_READ,  8'h00,    11'h7FF,  1,  1'b1, HOME_EMPTY};
    directed_rows[3]  = '{KIND_SPARE, 8'hFF,    11'h7FF,  1,  1'b1, HOME_EMPTY};
    directed_rows[4]  = '{KIND_PUT,   8'h20,    11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[5]  = '{KIND_PUT,   8'h7F,    11'h7FF,  1,  1'b0, HOME_EMPTY};
    directed_rows[6]  = '{KIND_PUT,   8'h80,    11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[7]  = '{KIND_PUT,   8'hFF,    11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[8]  = '{KIND_PUT,   8'h00,    11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[9]  = '{KIND_PUT,   8'h1F,    11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[10] = '{KIND_PUT,   CHAR_BS,  11'd0,    3,  1'b0, HOME_EMPTY};
    directed_rows[11] = '{KIND_PUT,   CHAR_TAB, 11'd0,    2,  1'b0, HOME_EMPTY};
    directed_rows[12] = '{KIND_PUT,   8'h41,    11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[13] = '{KIND_PUT,   CHAR_TAB, 11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[14] = '{KIND_PUT,   CHAR_CR,  11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[15] = '{KIND_READ,  8'h00,    11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[16] = '{KIND_READ,  8'h00,    11'd1,    1,  1'b0, HOME_EMPTY};
    directed_rows[17] = '{KIND_PUT,   CHAR_TAB, 11'd0,    10, 1'b0, HOME_EMPTY};
    directed_rows[18] = '{KIND_PUT,   CHAR_TAB, 11'd0,    9,  1'b0, HOME_EMPTY};
    directed_rows[19] = '{KIND_PUT,   8'h5A,    11'd0,    8,  1'b0, HOME_EMPTY};
    directed_rows[20] = '{KIND_PUT,   CHAR_LF,  11'd0,    23, 1'b0, HOME_EMPTY};
    directed_rows[21] = '{KIND_READ,  8'h00,    11'd0,    1,  1'b0, HOME_EMPTY};
    directed_rows[22] = '{KIND_READ,  8'h00,    11'd1999, 1,  1'b0, HOME_EMPTY};
    directed_rows[23] = '{KIND_CLEAR, 8'h00,    11'd0,    1,  1'b1, HOME_EMPTY};
    directed_rows[24] = '{KIND_READ,  8'h00,    11'd0,    1,  1'b1, HOME_BLANK};

    blank_screen();
    cur_col = 0;
    cur_row = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_colours(4'd15, 4'd0);

    for (k = 0; k < DIRECTED_ROWS; k++) begin
      w = '{kind: directed_rows[k].kind, char_code: directed_rows[k].code,
            cell_index: directed_rows[k].index};
      for (n = 0; n < directed_rows[k].reps; n++)
        send_word(w, directed_rows[k].typed, directed_rows[k].want);
    end
    in_valid <= 1'b0;

    for (p = 0; p < RANDOM_PHASES; p++) begin
      while (cursor_reports.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0:       set_colours(4'd0, 4'd0);
        1:       set_colours(4'd15, 4'd15);
        2:       set_colours(4'd0, 4'd15);
        default: set_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      for (k = 0; k < PHASE_WORDS; k++) send_word(random_console_word(), 1'b0, HOME_EMPTY);
      in_valid <= 1'b0;
    end

    while (cursor_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d words under %0d colour settings: %0d cell reads, %0d scrolls, %0d clears.",
             words_sent, colour_settings, read_count, scroll_count, clear_count);
    $display("Checked %0d result words, %0d faults.", reports_checked, fault_count);
    if (fault_count == 0) begin
      $display("text_console_char_writer_unit regression: pass");
    end else begin
      $display("text_console_char_writer_unit regression: fail");
    end
    $finish;
  end

endmodule
